// ===== rtl/core/jtp_pkg.sv =====
// ----------------------------------------------------------------------------
// Joint trajectory point - shared package
// Fixed-point formats, configuration register codes and the Q0.24 product.
// ----------------------------------------------------------------------------
package jtp_pkg;

    localparam int FRAC_W      = 24;           // Q0.24 fraction bits
    localparam int QW          = FRAC_W + 1;   // ratio / scale width, holds 1.0
    localparam int HALF_Q24    = 1 << (FRAC_W - 1);
    localparam int ONE_Q24     = 1 << FRAC_W;

    localparam int MAX_POINTS  = 1024;
    localparam int D_W         = $clog2(MAX_POINTS);  // width of points-1
    localparam int NP_W        = 11;
    localparam int IDX_W       = 10;
    localparam int ANGLE_W_DEF = 32;

    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SCALING_MODE = CFG_IDX_W'(1);

    localparam logic             MODE_CUBIC   = 1'b0;
    localparam logic             MODE_QUINTIC = 1'b1;
    localparam logic [NP_W-1:0]  NP_RESET     = NP_W'(2);
    localparam logic             MODE_RESET   = MODE_QUINTIC;

    typedef logic [QW-1:0] t_q24;

    // angle difference, wide enough to split off a 24-bit low part
    function automatic int diff_w(input int aw);
        return (aw + 1 > QW) ? aw + 1 : QW;
    endfunction

    // rounded Q0.24 product of two values in [0, 1.0]
    function automatic t_q24 mul_q24(input t_q24 a, input t_q24 b);
        logic [2*QW-1:0] p;
        p = (2*QW)'(a) * (2*QW)'(b) + (2*QW)'(HALF_Q24);
        return p[FRAC_W+QW-1:FRAC_W];
    endfunction

endpackage

// ===== rtl/core/jtp_ratio_div.sv =====
// ----------------------------------------------------------------------------
// Ratio divider
// Pipelined restoring divider, one quotient bit per stage:
// r = floor((idx * 2^24 + d/2) / d) in Q0.24.
// ----------------------------------------------------------------------------
module jtp_ratio_div #(
    parameter int SB_W = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic [jtp_pkg::D_W-1:0] i_idx,
    input  logic [jtp_pkg::D_W-1:0] i_d,
    input  logic [SB_W-1:0]         i_sb,
    output logic                    o_vld,
    output jtp_pkg::t_q24           o_ratio,
    output logic [SB_W-1:0]         o_sb
);
    import jtp_pkg::*;

    logic [QW:0]      r_vld, n_vld;
    logic [D_W-1:0]   r_rem [0:QW];
    logic [D_W-1:0]   n_rem [0:QW];
    logic [D_W-1:0]   r_d   [0:QW];
    logic [D_W-1:0]   n_d   [0:QW];
    logic [QW-1:0]    r_low [0:QW];
    logic [QW-1:0]    n_low [0:QW];
    logic [QW-1:0]    r_q   [0:QW];
    logic [QW-1:0]    n_q   [0:QW];
    logic [SB_W-1:0]  r_sb  [0:QW];
    logic [SB_W-1:0]  n_sb  [0:QW];
    logic [D_W:0]     part  [0:QW-1];

    // Quotient < 2^25, so the top of the dividend (idx >> 1) is already below d
    always_comb begin
        n_vld[0] = i_vld;
        n_rem[0] = i_idx >> 1;
        n_low[0] = {i_idx[0], FRAC_W'(i_d >> 1)};
        n_q[0]   = '0;
        n_d[0]   = i_d;
        n_sb[0]  = i_sb;
        for (int k = 0; k < QW; k++) begin
            part[k] = {r_rem[k], r_low[k][QW-1]};
            if (part[k] >= {1'b0, r_d[k]}) begin
                n_rem[k+1] = D_W'(part[k] - {1'b0, r_d[k]});
                n_q[k+1]   = {r_q[k][QW-2:0], 1'b1};
            end else begin
                n_rem[k+1] = part[k][D_W-1:0];
                n_q[k+1]   = {r_q[k][QW-2:0], 1'b0};
            end
            n_low[k+1] = {r_low[k][QW-2:0], 1'b0};
            n_d[k+1]   = r_d[k];
            n_sb[k+1]  = r_sb[k];
            n_vld[k+1] = r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= QW; k++) begin
            r_rem[k] <= n_rem[k];
            r_d[k]   <= n_d[k];
            r_low[k] <= n_low[k];
            r_q[k]   <= n_q[k];
            r_sb[k]  <= n_sb[k];
        end
    end

    assign o_vld   = r_vld[QW];
    assign o_ratio = r_q[QW];
    assign o_sb    = r_sb[QW];

endmodule

// ===== rtl/core/jtp_scale.sv =====
// ----------------------------------------------------------------------------
// Time scaling
// Powers r^2..r^5, one Q0.24 product per stage, then the cubic or
// quintic polynomial clamped to [0, 1.0].
// ----------------------------------------------------------------------------
module jtp_scale #(
    parameter int SB_W = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  jtp_pkg::t_q24   i_ratio,
    input  logic            i_mode,
    input  logic [SB_W-1:0] i_sb,
    output logic            o_vld,
    output jtp_pkg::t_q24   o_scale,
    output logic [SB_W-1:0] o_sb
);
    import jtp_pkg::*;

    localparam int POLY_W = FRAC_W + 6;
    localparam logic signed [POLY_W-1:0] K2  = POLY_W'(2);
    localparam logic signed [POLY_W-1:0] K3  = POLY_W'(3);
    localparam logic signed [POLY_W-1:0] K6  = POLY_W'(6);
    localparam logic signed [POLY_W-1:0] K10 = POLY_W'(10);
    localparam logic signed [POLY_W-1:0] K15 = POLY_W'(15);
    localparam logic signed [POLY_W-1:0] KONE = POLY_W'(ONE_Q24);

    logic [4:0]      r_vld;
    logic [3:0]      r_mode;
    logic [SB_W-1:0] r_sb [0:4];

    t_q24 r_s1_r1, r_s1_r2;
    t_q24 r_s2_r1, r_s2_r2, r_s2_r3;
    t_q24 r_s3_r1, r_s3_r2, r_s3_r3, r_s3_r4;
    t_q24 r_s4_r2, r_s4_r3, r_s4_r4, r_s4_r5;
    t_q24 r_scale;
    t_q24 n_scale;

    logic signed [POLY_W-1:0] x2, x3, x4, x5, poly;

    always_comb begin
        x2 = POLY_W'(r_s4_r2);
        x3 = POLY_W'(r_s4_r3);
        x4 = POLY_W'(r_s4_r4);
        x5 = POLY_W'(r_s4_r5);
        if (r_mode[3] == MODE_CUBIC) begin
            poly = K3 * x2 - K2 * x3;
        end else begin
            poly = K10 * x3 - K15 * x4 + K6 * x5;
        end
        priority if (poly < 0) begin
            n_scale = '0;
        end else if (poly > KONE) begin
            n_scale = QW'(ONE_Q24);
        end else begin
            n_scale = poly[QW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= {r_mode[2:0], i_mode};
        r_sb[0] <= i_sb;
        for (int k = 1; k < 5; k++) begin
            r_sb[k] <= r_sb[k-1];
        end

        r_s1_r1 <= i_ratio;
        r_s1_r2 <= mul_q24(i_ratio, i_ratio);

        r_s2_r1 <= r_s1_r1;
        r_s2_r2 <= r_s1_r2;
        r_s2_r3 <= mul_q24(r_s1_r2, r_s1_r1);

        r_s3_r1 <= r_s2_r1;
        r_s3_r2 <= r_s2_r2;
        r_s3_r3 <= r_s2_r3;
        r_s3_r4 <= mul_q24(r_s2_r3, r_s2_r1);

        r_s4_r2 <= r_s3_r2;
        r_s4_r3 <= r_s3_r3;
        r_s4_r4 <= r_s3_r4;
        r_s4_r5 <= mul_q24(r_s3_r4, r_s3_r1);

        r_scale <= n_scale;
    end

    assign o_vld   = r_vld[4];
    assign o_scale = r_scale;
    assign o_sb    = r_sb[4];

endmodule

// ===== rtl/core/jtp_interp.sv =====
// ----------------------------------------------------------------------------
// Interpolator
// start + round(s * (end - start) / 2^24), the product split into a low
// 24-bit and a high signed partial product.
// ----------------------------------------------------------------------------
module jtp_interp #(
    parameter int AW = jtp_pkg::ANGLE_W_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_vld,
    input  jtp_pkg::t_q24                         i_scale,
    input  logic [AW-1:0]                         i_start,
    input  logic signed [jtp_pkg::diff_w(AW)-1:0] i_diff,
    output logic                                  o_vld,
    output logic [AW-1:0]                         o_angle
);
    import jtp_pkg::*;

    localparam int DXW = diff_w(AW);
    localparam int DHW = DXW - FRAC_W;
    localparam int PLW = QW + FRAC_W;
    localparam int PHW = QW + DHW + 1;

    logic [2:0] r_vld;

    logic [FRAC_W-1:0]      dl;
    logic signed [DHW-1:0]  dh;
    logic signed [PHW-1:0]  ph;
    logic [PLW:0]           lo_full;

    logic [PLW-1:0] r_pl;
    logic [AW-1:0]  r_ph;
    logic [AW-1:0]  r_start;
    logic [QW:0]    r_lo;
    logic [AW-1:0]  r_t;
    logic [AW-1:0]  r_out;

    assign dl      = i_diff[FRAC_W-1:0];
    assign dh      = i_diff[DXW-1:FRAC_W];
    assign ph      = PHW'($signed({1'b0, i_scale})) * PHW'(dh);
    assign lo_full = (PLW+1)'(r_pl) + (PLW+1)'(HALF_Q24);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    // result lies between start and end, so modulo 2^AW arithmetic is exact
    always_ff @(posedge i_clk) begin
        r_pl    <= PLW'(i_scale) * PLW'(dl);
        r_ph    <= ph[AW-1:0];
        r_start <= i_start;

        r_lo    <= lo_full[PLW:FRAC_W];
        r_t     <= r_start + r_ph;

        r_out   <= r_t + AW'(r_lo);
    end

    assign o_vld   = r_vld[2];
    assign o_angle = r_out;

endmodule

// ===== rtl/core/joint_trajectory_point_top.sv =====
// ----------------------------------------------------------------------------
// Joint trajectory point - top level
// From accepted start to o_valid: combinational entry, then 26 divider, 5 scaling
// and 3 interpolation stages. Throughput: one transaction per cycle outside reset.
// Reset (synchronous, i_rst_n low) clears all in-flight transactions and sets
// num_points to 2, scaling_mode to quintic; busy is high and cfg ready low meanwhile.
// The receiver cannot stall: each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module joint_trajectory_point_top #(
    parameter int ANGLE_WIDTH = jtp_pkg::ANGLE_W_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command channel
    input  logic                             start,
    output logic                             busy,
    input  logic [jtp_pkg::IDX_W-1:0]        i_sample_index,
    input  logic signed [ANGLE_WIDTH-1:0]    i_angle_start,
    input  logic signed [ANGLE_WIDTH-1:0]    i_angle_end,
    // result strobe
    output logic                             o_valid,
    output logic signed [ANGLE_WIDTH-1:0]    o_angle_out,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [jtp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [jtp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import jtp_pkg::*;

    localparam int AW   = ANGLE_WIDTH;
    localparam int DXW  = diff_w(AW);
    localparam int SB_W = AW + DXW;     // start angle and difference

    // ------------------------------------------------------------------
    // Configuration registers. Write them only while idle, so the values sampled
    // at entry hold for every transaction in flight; the block does not enforce this.
    // ------------------------------------------------------------------
    logic [NP_W-1:0] r_num_points;
    logic            r_scaling_mode;
    logic            cfg_wr;

    assign o_cfg_ready = i_rst_n;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points   <= NP_RESET;
            r_scaling_mode <= MODE_RESET;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_NUM_POINTS:   r_num_points   <= i_cfg_data[NP_W-1:0];
                CFG_SCALING_MODE: r_scaling_mode <= i_cfg_data[0];
                default: ;        // unknown register index: write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Entry: the pipeline never stalls, so a transaction is taken whenever
    // start is high outside reset.
    // ------------------------------------------------------------------
    logic                   accept;
    logic [NP_W-1:0]        np_clamped;
    logic [D_W-1:0]         d;
    logic [NP_W-1:0]        idx_x;
    logic [D_W-1:0]         idx_sat;
    logic signed [DXW-1:0]  diff;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    always_comb begin
        // points below two act as two, above the maximum as the maximum
        priority if (r_num_points < NP_W'(2)) begin
            np_clamped = NP_W'(2);
        end else if (r_num_points > NP_W'(MAX_POINTS)) begin
            np_clamped = NP_W'(MAX_POINTS);
        end else begin
            np_clamped = r_num_points;
        end
        d     = D_W'(np_clamped - NP_W'(1));
        // index past the last sample saturates to the end point
        idx_x = NP_W'(i_sample_index);
        if (idx_x > NP_W'(d)) begin
            idx_sat = d;
        end else begin
            idx_sat = D_W'(idx_x);
        end
        diff = DXW'(i_angle_end) - DXW'(i_angle_start);
    end

    // ------------------------------------------------------------------
    // Ratio divider: r = idx / (points - 1) in Q0.24
    // ------------------------------------------------------------------
    logic            div_vld;
    t_q24            div_ratio;
    logic [SB_W:0]   div_sb;

    jtp_ratio_div #(
        .SB_W (SB_W + 1)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (accept),
        .i_idx   (idx_sat),
        .i_d     (d),
        .i_sb    ({i_angle_start, diff, r_scaling_mode}),
        .o_vld   (div_vld),
        .o_ratio (div_ratio),
        .o_sb    (div_sb)
    );

    // ------------------------------------------------------------------
    // Time scaling s(r), cubic or quintic
    // ------------------------------------------------------------------
    logic            scl_vld;
    t_q24            scl_scale;
    logic [SB_W-1:0] scl_sb;

    jtp_scale #(
        .SB_W (SB_W)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (div_vld),
        .i_ratio (div_ratio),
        .i_mode  (div_sb[0]),
        .i_sb    (div_sb[SB_W:1]),
        .o_vld   (scl_vld),
        .o_scale (scl_scale),
        .o_sb    (scl_sb)
    );

    // ------------------------------------------------------------------
    // Interpolation start + s * (end - start)
    // ------------------------------------------------------------------
    logic [AW-1:0] angle;

    jtp_interp #(
        .AW (AW)
    ) u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (scl_vld),
        .i_scale (scl_scale),
        .i_start (scl_sb[SB_W-1:DXW]),
        .i_diff  (scl_sb[DXW-1:0]),
        .o_vld   (o_valid),
        .o_angle (angle)
    );

    assign o_angle_out = angle;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// Joint trajectory point - testbench
// Streams sample commands through the block under a range of point counts and
// both time scalings. A scoreboard predicts each angle in fixed point and checks
// every result strobe in order. Sender gaps are random, apart from the last phases.
// ----------------------------------------------------------------------------
module tb;
    import jtp_pkg::*;

    localparam int AW             = ANGLE_W_DEF;
    localparam int PIPE_LATENCY   = 34;       // start accepted -> o_valid
    localparam int WATCHDOG_LIMIT = 1000;     // cycles with no transaction at all
    localparam int NUM_PHASES     = 16;
    localparam int PHASE_ITEMS    = 100;

    localparam logic signed [AW-1:0] ANGLE_MIN = {1'b1, {(AW-1){1'b0}}};
    localparam logic signed [AW-1:0] ANGLE_MAX = {1'b0, {(AW-1){1'b1}}};

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the two registers, angle predictor, FIFO of
    // predicted angles in strobe order.
    // ------------------------------------------------------------------------
    class trajectory_scoreboard;
        logic [NP_W-1:0]        points_reg;
        logic                   mode_reg;
        logic signed [AW-1:0]   pending_angles[$];
        int unsigned            mismatch_count;

        function new();
            points_reg     = NP_RESET;
            mode_reg       = MODE_RESET;
            mismatch_count = 0;
        endfunction

        // writes to indices other than the two registers fall through
        function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_NUM_POINTS:   points_reg = data[NP_W-1:0];
                CFG_SCALING_MODE: mode_reg   = data[0];
                default: ;
            endcase
        endfunction

        // last valid sample index, point count clamped to [2, MAX_POINTS]
        function int unsigned last_sample();
            int unsigned n;
            n = points_reg;
            if (n < 2) n = 2;
            if (n > MAX_POINTS) n = MAX_POINTS;
            return n - 1;
        endfunction

        function longint unsigned q24_product(longint unsigned a, longint unsigned b);
            return (a * b + HALF_Q24) >> FRAC_W;
        endfunction

        // s(r) in Q0.24, r = pos/span rounded
        function longint time_scaling(longint unsigned pos, longint unsigned span);
            longint unsigned r, r2, r3, r4, r5;
            longint s;
            r  = (pos * ONE_Q24 + span / 2) / span;
            r2 = q24_product(r, r);
            r3 = q24_product(r2, r);
            r4 = q24_product(r3, r);
            r5 = q24_product(r4, r);
            if (mode_reg == MODE_CUBIC) begin
                s = 3 * longint'(r2) - 2 * longint'(r3);
            end else begin
                s = 10 * longint'(r3) - 15 * longint'(r4) + 6 * longint'(r5);
            end
            if (s < 0) s = 0;
            if (s > ONE_Q24) s = ONE_Q24;
            return s;
        endfunction

        function logic signed [AW-1:0] interpolate(logic [IDX_W-1:0] idx,
                                                   logic signed [AW-1:0] a0,
                                                   logic signed [AW-1:0] a1);
            longint unsigned span, pos;
            longint s, diff, prod;
            logic signed [127:0] s_w, d_w, wide;
            span = last_sample();
            pos  = (idx > span) ? span : idx;
            s    = time_scaling(pos, span);
            diff = longint'(a1) - longint'(a0);
            s_w  = s;
            d_w  = diff;
            // floor((s*diff + half) / 2^24), done wide so nothing wraps
            wide = s_w * d_w + HALF_Q24;
            prod = longint'(wide >>> FRAC_W);
            return AW'(longint'(a0) + prod);
        endfunction

        function void note_command(logic [IDX_W-1:0] idx, logic signed [AW-1:0] a0,
                                   logic signed [AW-1:0] a1);
            pending_angles.push_back(interpolate(idx, a0, a1));
        endfunction

        function void check_result(logic signed [AW-1:0] angle);
            logic signed [AW-1:0] want;
            if (pending_angles.size() == 0) begin
                $error("angle_out: expected none, got %0d", angle);
                mismatch_count++;
                return;
            end
            want = pending_angles.pop_front();
            if (angle !== want) begin
                $error("angle_out: expected %0d, got %0d", want, angle);
                mismatch_count++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs - all known from time zero
    // ------------------------------------------------------------------------
    logic                         i_clk          = 1'b0;
    logic                         i_rst_n        = 1'b0;
    logic                         start          = 1'b0;
    logic                         busy;
    logic [IDX_W-1:0]             i_sample_index = '0;
    logic signed [AW-1:0]         i_angle_start  = '0;
    logic signed [AW-1:0]         i_angle_end    = '0;
    logic                         o_valid;
    logic signed [AW-1:0]         o_angle_out;
    logic                         i_cfg_valid    = 1'b0;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data     = '0;

    trajectory_scoreboard sb;
    int unsigned          quiet_cycles = 0;

    joint_trajectory_point_top #(.ANGLE_WIDTH(AW)) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_sample_index (i_sample_index),
        .i_angle_start  (i_angle_start),
        .i_angle_end    (i_angle_end),
        .o_valid        (o_valid),
        .o_angle_out    (o_angle_out),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge, before this edge's
    // nonblocking updates land, so the values seen are those the block saw.
    // The watchdog counts cycles with no transaction on any channel.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_cfg_valid && o_cfg_ready) begin
            sb.apply_write(i_cfg_index, i_cfg_data);
        end
        if (start && !busy) begin
            sb.note_command(i_sample_index, i_angle_start, i_angle_end);
        end
        if (o_valid) begin
            sb.check_result(o_angle_out);
        end
        if ((i_cfg_valid && o_cfg_ready) || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("joint_trajectory_point_top: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. All called at a rising edge; each leaves the caller at one.
    // ------------------------------------------------------------------------

    // one command transaction; start stays high after acceptance when gap is 0,
    // so back-to-back transactions never lower and raise it in the same step
    task automatic send_command(logic [IDX_W-1:0] idx, logic signed [AW-1:0] a0,
                                logic signed [AW-1:0] a1, int gap);
        start          <= 1'b1;
        i_sample_index <= idx;
        i_angle_start  <= a0;
        i_angle_end    <= a1;
        do @(posedge i_clk); while (busy);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // one register transaction; valid is left high for the next beat
    task automatic cfg_beat(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic drain();
        do @(posedge i_clk); while (sb.pending_angles.size() != 0);
    endtask

    // registers only change with the pipeline empty; the stray write goes to
    // an index past the register file and must leave both registers alone
    task automatic configure(logic [CFG_DATA_W-1:0] np_data, logic [CFG_DATA_W-1:0] mode_data,
                             logic [CFG_IDX_W-1:0] stray_idx, logic [CFG_DATA_W-1:0] stray_data);
        start <= 1'b0;
        drain();
        cfg_beat(CFG_NUM_POINTS, np_data);
        cfg_beat(CFG_SCALING_MODE, mode_data);
        cfg_beat(stray_idx, stray_data);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [AW-1:0] pick_angle();
        case ($urandom_range(0, 5))
            0:       return ANGLE_MIN;
            1:       return ANGLE_MAX;
            2:       return $urandom_range(0, 1) ? '0 : '1;
            default: return AW'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned          span;
        int                   gap;
        logic [IDX_W-1:0]     idx;
        logic signed [AW-1:0] a0, a1;
        logic [CFG_DATA_W-1:0] np_data;
        bit                   quiet;

        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: two points, quintic; past-the-end index saturates
        send_command(10'd0,    ANGLE_MIN, ANGLE_MAX, 0);
        send_command(10'd1,    ANGLE_MIN, ANGLE_MAX, 0);
        send_command(10'd1023, ANGLE_MAX, ANGLE_MIN, 1);
        send_command(10'd0,    ANGLE_MAX, ANGLE_MIN, 0);

        // longest trajectory, cubic
        configure(16'h0400, 16'h0000, 4'd15, 16'hFFFF);
        send_command(10'd0,    ANGLE_MIN, ANGLE_MAX, 0);
        send_command(10'd1,    ANGLE_MIN, ANGLE_MAX, 0);
        send_command(10'd511,  ANGLE_MAX, ANGLE_MIN, 0);
        send_command(10'd1022, ANGLE_MIN, ANGLE_MAX, 2);
        send_command(10'd1023, '1,        '1,        0);

        // longest trajectory, quintic
        configure(16'h0400, 16'h0001, 4'd2, 16'h0000);
        send_command(10'd1,    ANGLE_MAX, ANGLE_MIN, 0);
        send_command(10'd511,  ANGLE_MIN, ANGLE_MAX, 0);
        send_command(10'd1022, ANGLE_MAX, ANGLE_MIN, 0);

        // too few points (zero), mode bit 0 under set upper bits
        configure(16'h0000, 16'hFFFE, 4'd3, 16'h5A5A);
        send_command(10'd1,    ANGLE_MIN, ANGLE_MAX, 0);
        send_command(10'd2,    ANGLE_MAX, '0,        0);

        // too many points (low bits all set), quintic
        configure(16'hFFFF, 16'hFFFF, 4'd8, 16'hA5A5);
        send_command(10'd511,  ANGLE_MIN, ANGLE_MAX, 0);
        send_command(10'd1023, ANGLE_MAX, ANGLE_MIN, 0);

        // too few points (one), cubic; 1025 just past the maximum follows
        configure(16'h0001, 16'h0000, 4'd4, 16'h0F0F);
        send_command(10'd0,    '0,        ANGLE_MAX, 0);
        send_command(10'd1,    '0,        ANGLE_MAX, 0);
        configure(16'h0401, 16'h0001, 4'd7, 16'hF0F0);
        send_command(10'd1023, ANGLE_MIN, '0,        0);
        send_command(10'd300,  ANGLE_MIN, '0,        0);

        // random phases; the last two run with no sender gaps
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            np_data = 16'($urandom);
            case ($urandom_range(0, 7))
                0:       np_data[NP_W-1:0] = NP_W'($urandom_range(0, 1));
                1:       np_data[NP_W-1:0] = NP_W'($urandom_range(2, 8));
                2:       np_data[NP_W-1:0] = NP_W'(MAX_POINTS);
                3:       np_data[NP_W-1:0] = NP_W'($urandom_range(MAX_POINTS + 1, 2047));
                4:       ;
                default: np_data[NP_W-1:0] = NP_W'($urandom_range(2, MAX_POINTS));
            endcase
            configure(np_data, 16'($urandom), CFG_IDX_W'($urandom_range(2, 15)),
                      16'($urandom));
            span  = sb.last_sample();
            quiet = (phase >= NUM_PHASES - 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(0, 9))
                    0:       idx = '0;
                    1:       idx = IDX_W'(span);
                    2:       idx = IDX_W'($urandom_range(span, 1023));
                    default: idx = IDX_W'($urandom_range(0, span));
                endcase
                a0 = pick_angle();
                // sometimes a short move, so small differences get exercised
                a1 = ($urandom_range(0, 3) == 0) ? a0 + AW'($urandom_range(0, 1 << 20))
                                                  : pick_angle();
                gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
                send_command(idx, a0, a1, gap);
            end
        end

        start <= 1'b0;
        drain();
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending_angles.size() == 0) begin
            $display("joint_trajectory_point_top: match");
        end else begin
            $display("joint_trajectory_point_top: mismatch");
        end
        $finish;
    end

endmodule
